### rtl/tvns_pkg.sv
// Shared types, constants and the note frequency table of the three-voice note sequencer.
package tvns_pkg;

   localparam int PATTERN_DEPTH = 128;
   localparam int NOTE_COUNT    = 48;
   localparam int VOICES        = 3;
   localparam int POS_W         = $clog2(PATTERN_DEPTH);
   localparam int LEN_W         = 8;
   localparam int LOOP_W        = 7;
   localparam int NOTE_W        = 8;
   localparam int HOLD_W        = 8;
   localparam int FREQ_W        = 16;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;
   localparam logic [1:0] REQ_STOP  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_MELODY_LENGTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HARMONY_LENGTH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASS_LENGTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MELODY_LOOP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HARMONY_LOOP   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASS_LOOP      = 3'd5;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [1:0]       voice_sel;
      logic [6:0]       entry_index;
      logic [NOTE_W-1:0] note_value;
      logic [HOLD_W-1:0] hold_ticks;
   } req_item_type;

   typedef struct packed {
      logic              tick;
      logic              start;
      logic              stop;
      logic              wr_en;
      logic [POS_W-1:0]  wr_index;
      logic [NOTE_W-1:0] wr_note;
      logic [HOLD_W-1:0] wr_hold;
      logic [LEN_W-1:0]  length;
      logic [LOOP_W-1:0] restart_entry;
      logic              bass;
   } voice_ctl_type;

   typedef struct packed {
      logic              retrigger;
      logic              gate;
      logic [FREQ_W-1:0] frequency;
   } voice_out_type;

   function automatic logic [FREQ_W-1:0] note_frequency(input logic [NOTE_W-1:0] note);
      logic [FREQ_W-1:0] f;
      unique case (note)
         8'd1:  f = 16'd1076;   8'd2:  f = 16'd1140;   8'd3:  f = 16'd1208;
         8'd4:  f = 16'd1280;   8'd5:  f = 16'd1356;   8'd6:  f = 16'd1437;
         8'd7:  f = 16'd1523;   8'd8:  f = 16'd1614;   8'd9:  f = 16'd1710;
         8'd10: f = 16'd1812;   8'd11: f = 16'd1920;   8'd12: f = 16'd2034;
         8'd13: f = 16'd2152;   8'd14: f = 16'd2281;   8'd15: f = 16'd2416;
         8'd16: f = 16'd2559;   8'd17: f = 16'd2711;   8'd18: f = 16'd2873;
         8'd19: f = 16'd3046;   8'd20: f = 16'd3229;   8'd21: f = 16'd3421;
         8'd22: f = 16'd3625;   8'd23: f = 16'd3840;   8'd24: f = 16'd4068;
         8'd25: f = 16'd4305;   8'd26: f = 16'd4562;   8'd27: f = 16'd4833;
         8'd28: f = 16'd5119;   8'd29: f = 16'd5423;   8'd30: f = 16'd5746;
         8'd31: f = 16'd6092;   8'd32: f = 16'd6458;   8'd33: f = 16'd6843;
         8'd34: f = 16'd7251;   8'd35: f = 16'd7680;   8'd36: f = 16'd8137;
         8'd37: f = 16'd8610;   8'd38: f = 16'd9125;   8'd39: f = 16'd9667;
         8'd40: f = 16'd10239;  8'd41: f = 16'd10847;  8'd42: f = 16'd11493;
         8'd43: f = 16'd12184;  8'd44: f = 16'd12916;  8'd45: f = 16'd13686;
         8'd46: f = 16'd14502;  8'd47: f = 16'd15361;  8'd48: f = 16'd16274;
         default: f = 16'd0;
      endcase
      return f;
   endfunction

endpackage

### rtl/tvns_voice.sv
// One sequencer voice: pattern memory with prefetched entry, position, countdown and gate state.
module tvns_voice (
   input  logic                    clock,
   input  logic                    reset,
   input  tvns_pkg::voice_ctl_type ctl,
   output tvns_pkg::voice_out_type result
);

   logic [15:0] mem [tvns_pkg::PATTERN_DEPTH];
   logic [15:0] rd_ff;
   logic [15:0] wdata_ff;
   logic        byp_ff;
   logic [15:0] wdata;
   logic [15:0] entry;

   logic [tvns_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [tvns_pkg::HOLD_W-1:0] cnt_ff, cnt_in;
   logic                        trk_ff, trk_in;
   logic                        gate_ff, gate_in;
   logic [tvns_pkg::FREQ_W-1:0] freq_ff, freq_in;
   logic                        retrig;
   logic [tvns_pkg::NOTE_W-1:0] note;
   logic                        rest;
   logic [tvns_pkg::LEN_W-1:0]  nxt;

   assign wdata = {ctl.wr_note, ctl.wr_hold};

   // The entry at the next position is read every cycle; a same-cycle write to it is forwarded.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_index] <= wdata;
      end
      rd_ff    <= mem[pos_in];
      byp_ff   <= ctl.wr_en && (ctl.wr_index == pos_in);
      wdata_ff <= wdata;
   end

   assign entry = byp_ff ? wdata_ff : rd_ff;
   assign note  = entry[15:8];
   assign rest  = (note == '0) || (note > tvns_pkg::NOTE_W'(tvns_pkg::NOTE_COUNT));
   assign nxt   = tvns_pkg::LEN_W'(pos_ff) + tvns_pkg::LEN_W'(1);

   always_comb begin
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      trk_in  = trk_ff;
      gate_in = gate_ff;
      freq_in = freq_ff;
      retrig  = 1'b0;
      priority if (ctl.start) begin
         pos_in = '0;
         cnt_in = '0;
         trk_in = 1'b0;
      end else if (ctl.stop) begin
         gate_in = 1'b0;
      end else if (ctl.tick) begin
         if (cnt_ff == '0) begin
            if (rest) begin
               gate_in = 1'b0;
               trk_in  = 1'b0;
            end else begin
               retrig  = !trk_ff || ctl.bass;
               freq_in = tvns_pkg::note_frequency(note);
               gate_in = 1'b1;
               trk_in  = 1'b1;
            end
            cnt_in = entry[7:0] - 8'd1;
            if ((nxt >= ctl.length) ||
                (nxt == tvns_pkg::LEN_W'(tvns_pkg::PATTERN_DEPTH))) begin
               pos_in = tvns_pkg::POS_W'(ctl.restart_entry);
            end else begin
               pos_in = nxt[tvns_pkg::POS_W-1:0];
            end
         end else begin
            cnt_in = cnt_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         cnt_ff  <= '0;
         trk_ff  <= 1'b0;
         gate_ff <= 1'b0;
         freq_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
         trk_ff  <= trk_in;
         gate_ff <= gate_in;
         freq_ff <= freq_in;
      end
   end

   assign result.frequency = freq_in;
   assign result.gate      = gate_in;
   assign result.retrigger = retrig;

endmodule

### rtl/three_voice_note_sequencer.sv
// Top level of the three-voice note sequencer: input register, voices, result register, registers.
//
// Items arrive on req_ (req_tuser is the request type: tick, pattern write, start or stop)
// and every item gives exactly one result on rsp_ carrying the run flag and, per voice,
// the frequency word, gate bit and retrigger pulse after that item.
// An accepted item is held in the input register and worked on once the result register
// is free; its result is then held in the result register and shown on rsp_tvalid. One
// item is taken every cycle while the receiver takes the results: each voice reads its
// pattern memory at its next position ahead of time, so the entry is ready when the item
// is worked on.
// Registers are to be written through csr_ only while the block is idle; the block does
// not enforce this. Lengths sit at indexes 0 to 2 and loop points at indexes 3 to 5.
// Lengths reset to 1 and loop points to 0. Reset stops play, clears positions, countdowns,
// gates and frequency words and empties both registers. Pattern memories are not cleared
// and must be written before use. While the receiver stalls, the result is held and one
// more item waits in the input register; req_tready then drops until the result is taken.
module three_voice_note_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // voice_sel, entry_index, note_value, hold_ticks, zero pad
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // playing_flag, then per voice 1..3: frequency, gate, retrigger; zero pad
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [tvns_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]  csr_wdata
);

   tvns_pkg::req_item_type  in_ff;
   logic                    in_valid_ff;
   logic                    exec_fire;
   logic                    run_ff, run_in;
   logic                    rsp_valid_ff;
   logic [55:0]             rsp_data_ff;
   logic [55:0]             rsp_data_in;
   logic [tvns_pkg::LEN_W-1:0]  len_ff  [tvns_pkg::VOICES];
   logic [tvns_pkg::LOOP_W-1:0] loop_ff [tvns_pkg::VOICES];
   tvns_pkg::voice_ctl_type ctl [tvns_pkg::VOICES];
   tvns_pkg::voice_out_type vout [tvns_pkg::VOICES];

   assign exec_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || exec_fire;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ff.req_type    <= req_tuser;
         in_ff.voice_sel   <= req_tdata[1:0];
         in_ff.entry_index <= req_tdata[8:2];
         in_ff.note_value  <= req_tdata[16:9];
         in_ff.hold_ticks  <= req_tdata[24:17];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < tvns_pkg::VOICES; v++) begin
            len_ff[v]  <= tvns_pkg::LEN_W'(1);
            loop_ff[v] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            tvns_pkg::CSR_MELODY_LENGTH:  len_ff[0]  <= csr_wdata;
            tvns_pkg::CSR_HARMONY_LENGTH: len_ff[1]  <= csr_wdata;
            tvns_pkg::CSR_BASS_LENGTH:    len_ff[2]  <= csr_wdata;
            tvns_pkg::CSR_MELODY_LOOP:    loop_ff[0] <= csr_wdata[6:0];
            tvns_pkg::CSR_HARMONY_LOOP:   loop_ff[1] <= csr_wdata[6:0];
            tvns_pkg::CSR_BASS_LOOP:      loop_ff[2] <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      run_in = run_ff;
      if (exec_fire && (in_ff.req_type == tvns_pkg::REQ_START)) begin
         run_in = 1'b1;
      end else if (exec_fire && (in_ff.req_type == tvns_pkg::REQ_STOP)) begin
         run_in = 1'b0;
      end
   end

   always_comb begin
      for (int v = 0; v < tvns_pkg::VOICES; v++) begin
         ctl[v].tick          = exec_fire && run_ff && (in_ff.req_type == tvns_pkg::REQ_TICK);
         ctl[v].start         = exec_fire && (in_ff.req_type == tvns_pkg::REQ_START);
         ctl[v].stop          = exec_fire && (in_ff.req_type == tvns_pkg::REQ_STOP);
         ctl[v].wr_en         = exec_fire && (in_ff.req_type == tvns_pkg::REQ_WRITE) &&
                                (in_ff.voice_sel == 2'(v));
         ctl[v].wr_index      = tvns_pkg::POS_W'(in_ff.entry_index);
         ctl[v].wr_note       = in_ff.note_value;
         ctl[v].wr_hold       = in_ff.hold_ticks;
         ctl[v].length        = len_ff[v];
         ctl[v].restart_entry = loop_ff[v];
         ctl[v].bass          = (v == tvns_pkg::VOICES - 1);
      end
   end

   for (genvar g = 0; g < tvns_pkg::VOICES; g++) begin : g_voice
      tvns_voice u_voice (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[g]),
         .result (vout[g])
      );
   end

   assign rsp_data_in = {1'b0, vout[2], vout[1], vout[0], run_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A retriggered voice always ends the item with its gate set.
   a_retrig_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((!rsp_tdata[18] || rsp_tdata[17]) && (!rsp_tdata[36] || rsp_tdata[35]) &&
                      (!rsp_tdata[54] || rsp_tdata[53])))
      else $error("retrigger without gate");

   // Retriggers happen only while playing.
   a_retrig_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[18] || rsp_tdata[36] || rsp_tdata[54])) |-> rsp_tdata[0])
      else $error("retrigger while stopped");

   // A stop item leaves every gate low and play halted.
   a_stop_gates: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && (in_ff.req_type == tvns_pkg::REQ_STOP)) |=>
      (!rsp_tdata[0] && !rsp_tdata[17] && !rsp_tdata[35] && !rsp_tdata[53]))
      else $error("gate still set after stop");

endmodule
